// ----- sv/numlit_pkg.sv -----
// Shared types, character codes and class functions for the numeric literal scanner.
package numlit_pkg;

  localparam int unsigned LENGTH_BITS = 12;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_EXP_U = 8'h45;
  localparam logic [7:0] CH_EXP_L = 8'h65;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_LEAD  = 10'b00_0000_0010,
    PH_SIGN  = 10'b00_0000_0100,
    PH_INT   = 10'b00_0000_1000,
    PH_DOT   = 10'b00_0001_0000,
    PH_FRAC  = 10'b00_0010_0000,
    PH_EXPM  = 10'b00_0100_0000,
    PH_EXPS  = 10'b00_1000_0000,
    PH_EXPD  = 10'b01_0000_0000,
    PH_TRAIL = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic       start_of_text;
    logic [7:0] text_char;
  } in_beat_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] number_length;
    logic                   length_saturated;
  } out_beat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_expo(input logic [7:0] c);
    return (c == CH_EXP_U) || (c == CH_EXP_L);
  endfunction

endpackage

// ----- sv/numlit_core.sv -----
// Scan state registers and the per-character step logic.
module numlit_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 step_en,
  input  numlit_pkg::in_beat_t step_data,
  output logic                 res_valid,
  output numlit_pkg::out_beat_t res_data
);
  import numlit_pkg::*;

  phase_t                 phase_r, phase_nxt, ph_e;
  logic [LENGTH_BITS-1:0] pos_r, pos_nxt, pos_e;
  logic [LENGTH_BITS-1:0] mark_r, mark_nxt, mark_e;
  logic                   dseen_r, dseen_nxt, ds_e;
  logic                   sat_r, sat_nxt, sat_e;
  logic                   cts_r;
  logic [7:0]             c;
  logic                   take, emit;
  phase_t                 take_ph;
  logic [LENGTH_BITS-1:0] emit_len;

  assign c = step_data.text_char;

  always_comb begin
    ph_e   = phase_r;
    pos_e  = pos_r;
    mark_e = mark_r;
    ds_e   = dseen_r;
    sat_e  = sat_r;
    if (step_data.start_of_text) begin
      ph_e   = PH_LEAD;
      pos_e  = '0;
      mark_e = '0;
      ds_e   = 1'b0;
      sat_e  = 1'b0;
    end
  end

  always_comb begin
    take      = 1'b0;
    take_ph   = PH_IDLE;
    emit      = 1'b0;
    emit_len  = pos_e;
    mark_nxt  = mark_e;
    dseen_nxt = ds_e;
    unique case (ph_e)
      PH_LEAD, PH_SIGN: begin
        if (ph_e == PH_LEAD && is_space(c)) begin
          take = 1'b1; take_ph = PH_LEAD;
        end else if (ph_e == PH_LEAD && is_sign(c)) begin
          take = 1'b1; take_ph = PH_SIGN;
        end else if (is_digit(c)) begin
          dseen_nxt = 1'b1; take = 1'b1; take_ph = PH_INT;
        end else if (c == CH_POINT) begin
          take = 1'b1; take_ph = PH_DOT;
        end else begin
          emit = 1'b1; emit_len = '0;
        end
      end
      PH_INT, PH_DOT, PH_FRAC, PH_EXPD: begin
        if (is_digit(c)) begin
          take = 1'b1;
          take_ph = (ph_e == PH_DOT) ? PH_FRAC : ph_e;
          if (ph_e == PH_DOT) dseen_nxt = 1'b1;
        end else if (ph_e == PH_INT && c == CH_POINT) begin
          take = 1'b1; take_ph = PH_DOT;
        end else if (ph_e == PH_DOT && !ds_e) begin
          emit = 1'b1; emit_len = '0;
        end else if (ph_e != PH_EXPD && is_expo(c)) begin
          mark_nxt = pos_e; take = 1'b1; take_ph = PH_EXPM;
        end else if (cts_r && is_space(c)) begin
          take = 1'b1; take_ph = PH_TRAIL;
        end else begin
          emit = 1'b1;
        end
      end
      PH_EXPM, PH_EXPS: begin
        if (ph_e == PH_EXPM && is_sign(c)) begin
          take = 1'b1; take_ph = PH_EXPS;
        end else if (is_digit(c)) begin
          take = 1'b1; take_ph = PH_EXPD;
        end else begin
          emit = 1'b1; emit_len = mark_e;
        end
      end
      PH_TRAIL: begin
        if (is_space(c)) begin
          take = 1'b1; take_ph = PH_TRAIL;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
      end
    endcase

    pos_nxt   = pos_e;
    sat_nxt   = sat_e;
    phase_nxt = emit ? PH_IDLE : ph_e;
    if (take) begin
      phase_nxt = take_ph;
      if (pos_e == LEN_MAX) begin
        sat_nxt = 1'b1;
      end else begin
        pos_nxt = pos_e + 1'b1;
      end
    end
  end

  assign res_valid                 = step_en && emit;
  assign res_data.number_length    = emit_len;
  assign res_data.length_saturated = sat_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      mark_r  <= '0;
      dseen_r <= 1'b0;
      sat_r   <= 1'b0;
      cts_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) cts_r <= cfg_wr_data;
      if (step_en) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        mark_r  <= mark_nxt;
        dseen_r <= dseen_nxt;
        sat_r   <= sat_nxt;
      end
    end
  end

endmodule

// ----- sv/numeric_literal_length_scanner.sv -----
// Top level: input beat register, scan core and result register.
// Output: the core's result enters the result register as the closing beat steps.
// Throughput: one character per cycle unless stalled; the scan step is combinational.
// Stalls on the result side hold the input register and, through it, in_stall.
// Reset (rst_n low, synchronous) clears the valid flags of both registers,
// the scan state and the trailing-space register; then it waits for a start of text.
module numeric_literal_length_scanner (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  numlit_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output numlit_pkg::out_beat_t out_data,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data
);
  import numlit_pkg::*;

  logic      in_vld_r;
  in_beat_t  in_data_r;
  logic      out_vld_r;
  out_beat_t out_data_r;
  logic      advance, step_en, res_valid;
  out_beat_t res_data;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign step_en  = in_vld_r && advance;

  numlit_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .step_en    (step_en),
    .step_data  (in_data_r),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (advance) out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
    if (advance && res_valid) out_data_r <= res_data;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/sv/numeric_literal_length_scanner_tb.sv -----
// Self-checking testbench for the numeric literal length scanner: random and directed texts.
`timescale 1ns / 1ps

module numeric_literal_length_scanner_tb;
  import numlit_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BEATS  = 400;
  localparam int LONG_TEXT    = 4100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;

  numeric_literal_length_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  in_beat_t  pending_beats[$];
  out_beat_t expected_results[$];
  out_beat_t want;
  int        failures = 0;
  int        phase_beats = 0;
  int        idle_left = 0;
  int        stall_left = 0;
  int        hold_token = 0;
  int        holds_served = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;

  // predicted scan state, following the same rules as the block
  phase_t               scan_ph = PH_IDLE;
  logic [LENGTH_BITS-1:0] scan_pos = '0;
  logic [LENGTH_BITS-1:0] exp_pos = '0;
  bit                   seen_digit = 1'b0;
  bit                   pos_sat = 1'b0;
  bit                   trail_cfg = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit ws_char(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic bit sign_char(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic bit exp_char(input logic [7:0] c);
    return c == CH_EXP_U || c == CH_EXP_L;
  endfunction

  function automatic void advance(input phase_t nxt);
    if (scan_pos == LEN_MAX) pos_sat = 1'b1;
    else scan_pos = scan_pos + 1'b1;
    scan_ph = nxt;
  endfunction

  function automatic void close_literal(input logic [LENGTH_BITS-1:0] len);
    out_beat_t r;
    r.number_length = len;
    r.length_saturated = pos_sat;
    expected_results.push_back(r);
    scan_ph = PH_IDLE;
  endfunction

  function automatic void number_done(input logic [7:0] c);
    if (trail_cfg && ws_char(c)) advance(PH_TRAIL);
    else close_literal(scan_pos);
  endfunction

  function automatic void mark_exponent();
    exp_pos = scan_pos;
    advance(PH_EXPM);
  endfunction

  function automatic void predict_beat(input in_beat_t b);
    logic [7:0] c;
    c = b.text_char;
    if (b.start_of_text) begin
      scan_ph = PH_LEAD;
      scan_pos = '0;
      exp_pos = '0;
      seen_digit = 1'b0;
      pos_sat = 1'b0;
    end
    case (scan_ph)
      PH_LEAD, PH_SIGN: begin
        if (scan_ph == PH_LEAD && ws_char(c)) advance(PH_LEAD);
        else if (scan_ph == PH_LEAD && sign_char(c)) advance(PH_SIGN);
        else if (digit_char(c)) begin
          seen_digit = 1'b1;
          advance(PH_INT);
        end else if (c == CH_POINT) advance(PH_DOT);
        else close_literal('0);
      end
      PH_INT: begin
        if (digit_char(c)) advance(PH_INT);
        else if (c == CH_POINT) advance(PH_DOT);
        else if (exp_char(c)) mark_exponent();
        else number_done(c);
      end
      PH_DOT: begin
        if (digit_char(c)) begin
          seen_digit = 1'b1;
          advance(PH_FRAC);
        end else if (!seen_digit) close_literal('0);
        else if (exp_char(c)) mark_exponent();
        else number_done(c);
      end
      PH_FRAC: begin
        if (digit_char(c)) advance(PH_FRAC);
        else if (exp_char(c)) mark_exponent();
        else number_done(c);
      end
      PH_EXPM: begin
        if (sign_char(c)) advance(PH_EXPS);
        else if (digit_char(c)) advance(PH_EXPD);
        else close_literal(exp_pos);
      end
      PH_EXPS: begin
        if (digit_char(c)) advance(PH_EXPD);
        else close_literal(exp_pos);
      end
      PH_EXPD: begin
        if (digit_char(c)) advance(PH_EXPD);
        else number_done(c);
      end
      PH_TRAIL: begin
        if (ws_char(c)) advance(PH_TRAIL);
        else close_literal(scan_pos);
      end
      default: scan_ph = PH_IDLE;
    endcase
  endfunction

  function automatic void push_char(input bit sot, input logic [7:0] c, input bit counted);
    in_beat_t b;
    b.start_of_text = sot;
    b.text_char = c;
    pending_beats.push_back(b);
    if (counted) phase_beats++;
  endfunction

  function automatic void queue_string(input string s, input logic [7:0] stop);
    for (int i = 0; i < s.len(); i++) push_char(i == 0, s[i], 1'b1);
    push_char(1'b0, stop, 1'b1);
  endfunction

  function automatic logic [7:0] rand_ws();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(9 + r);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(48 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
  endfunction

  function automatic logic [7:0] rand_special();
    case ($urandom_range(0, 6))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_POINT;
      3: return CH_EXP_U;
      4: return CH_EXP_L;
      5: return rand_digit();
      default: return rand_ws();
    endcase
  endfunction

  // literal-like text with random optional parts (not always well formed), then an optional random ending
  function automatic void queue_literal();
    logic [7:0] t[$];
    repeat ($urandom_range(0, 3)) t.push_back(rand_ws());
    if ($urandom_range(0, 2) == 0) t.push_back(rand_sign());
    repeat ($urandom_range(0, 5)) t.push_back(rand_digit());
    if ($urandom_range(0, 2) == 0) begin
      t.push_back(CH_POINT);
      repeat ($urandom_range(0, 4)) t.push_back(rand_digit());
    end
    if ($urandom_range(0, 2) == 0) begin
      t.push_back($urandom_range(0, 1) ? CH_EXP_U : CH_EXP_L);
      if ($urandom_range(0, 1)) t.push_back(rand_sign());
      repeat ($urandom_range(0, 3)) t.push_back(rand_digit());
    end
    repeat ($urandom_range(0, 3)) t.push_back(rand_ws());
    case ($urandom_range(0, 5))
      0: t.push_back(8'h00);
      1: t.push_back(8'($urandom_range(0, 255)));
      2: t.push_back(8'($urandom_range(97, 122)));
      3: t.push_back(8'h3B);
      4: t.push_back(rand_ws());
      default: ;
    endcase
    for (int i = 0; i < t.size(); i++) push_char(i == 0, t[i], 1'b1);
    repeat ($urandom_range(0, 2)) push_char(1'b0, 8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic void queue_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      push_char(i == 0 || $urandom_range(0, 9) == 0,
                $urandom_range(0, 1) ? rand_special() : 8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void queue_long_text(input bit digits);
    push_char(1'b1, digits ? rand_digit() : rand_ws(), 1'b0);
    repeat (LONG_TEXT - 1) push_char(1'b0, digits ? rand_digit() : rand_ws(), 1'b0);
    push_char(1'b0, CH_SPACE, 1'b0);
    push_char(1'b0, 8'h78, 1'b0);
  endfunction

  task automatic write_trail_cfg(input bit v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    trail_cfg = v;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left <= 0;
    end else begin
      if (in_valid && !in_stall) predict_beat(in_data);
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          in_valid <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          idle_left <= $urandom_range(0, 3);
        end else if (pending_beats.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat, actual len=%0d sat=%0b", $time,
                   out_data.number_length, out_data.length_saturated);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.number_length != want.number_length) begin
            $display("%0t: number_length expected %0d actual %0d", $time,
                     want.number_length, out_data.number_length);
            failures++;
          end
          if (out_data.length_saturated != want.length_saturated) begin
            $display("%0t: length_saturated expected %0b actual %0b", $time,
                     want.length_saturated, out_data.length_saturated);
            failures++;
          end
        end
      end
      if (hold_token != holds_served) begin
        holds_served <= holds_served + 1;
        out_stall <= 1'b1;
        stall_left <= HOLD_CYCLES - 1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("numeric_literal_length_scanner_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      write_trail_cfg(p[0]);
      phase_beats = 0;
      if (p == 3) calm <= 1'b1;
      if (p == 0) begin
        push_char(1'b0, 8'h71, 1'b0);
        queue_string(" -1.5e+3", 8'h00);
        queue_string(".", CH_EXP_L);
        queue_string("1e+", 8'hFF);
        queue_string("7.", 8'h3B);
        push_char(1'b1, 8'h31, 1'b1);
        push_char(1'b0, 8'h32, 1'b1);
        queue_string("+", 8'h78);
      end else if (p == 1) begin
        queue_string("5 \t", 8'h78);
        queue_string("2E", CH_SPACE);
        queue_string("3e-4 ", 8'h00);
        queue_long_text(1'b1);
      end else if (p == 2) begin
        queue_long_text(1'b0);
      end
      while (phase_beats < PHASE_BEATS) begin
        if ($urandom_range(0, 9) < 8) queue_literal();
        else queue_noise();
      end
      if (p == 1) hold_token <= hold_token + 1;
      drain();
    end
    if (failures == 0 && expected_results.size() == 0)
      $display("numeric_literal_length_scanner_tb OK");
    else
      $display("numeric_literal_length_scanner_tb NOT OK");
    $finish;
  end

endmodule
